FILE: rtl/bfts_pkg.sv
// Package for the bilinear fog tile shader: shared constants, codes and types.
// Used by the controller, the datapath and the top level; depends on nothing.
package bfts_pkg;

  // Geometry and field widths.
  localparam int TILE_SIZE     = 32;
  localparam int TILE_BITS     = $clog2(TILE_SIZE);
  localparam int SIZE_BITS     = TILE_BITS + 1;
  localparam int COORD_BITS    = 12;
  localparam int POS_BITS      = COORD_BITS + 1;
  localparam int LEVEL_BITS    = 8;
  localparam int COLOR_BITS    = 8;
  localparam int TBL_ADDR_BITS = LEVEL_BITS + COLOR_BITS;
  localparam int TBL_DEPTH     = 1 << TBL_ADDR_BITS;
  localparam int IN_DATA_BITS  = 96;
  localparam int OUT_DATA_BITS = 48;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  // Width of the 12.8 interpolation arithmetic and the rounding offset.
  localparam int FRAC_BITS  = 20;
  localparam int QUOT_BITS  = FRAC_BITS - TILE_BITS;
  localparam int STEP_BITS  = LEVEL_BITS + 4;
  localparam logic [FRAC_BITS-1:0] LEVEL_ROUND = FRAC_BITS'(8'h80);

  // Operation codes carried on the input tuser.
  typedef logic [1:0] op_t;
  localparam op_t OP_TBL_WR     = 2'd0;
  localparam op_t OP_TILE_START = 2'd1;
  localparam op_t OP_PIXEL      = 2'd2;

  // Result kinds carried on the output tuser.
  localparam logic KIND_TILE  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Configuration register indexes (byte address divided by four).
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_WIN_MIN_X = 2'd0;
  localparam reg_idx_t REG_WIN_MIN_Y = 2'd1;
  localparam reg_idx_t REG_WIN_MAX_X = 2'd2;
  localparam reg_idx_t REG_WIN_MAX_Y = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TILE_CLIP,
    ST_TILE_RESP,
    ST_PIX_MUL,
    ST_PIX_DIV,
    ST_PIX_ADDR,
    ST_PIX_LOOK,
    ST_PIX_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tbl_wr;
    logic tile_start;
    logic tile_commit;
    logic tile_load;
    logic px_start;
    logic px_mul;
    logic px_div;
    logic px_addr;
    logic px_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tile_active;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/bilinear_fog_tile_shader.sv
// Bilinear fog tile shader: stream ports, clip window registers and assertions.
// Depends on bfts_pkg, bfts_ctrl, bfts_dp and bfts_ram.
//
// The block works on one beat at a time. A table write beat is written as
// it is accepted. A tile start beat runs clip low edge, clip high edge and
// answer in turn before the next beat is accepted. A pixel beat runs the two
// interpolation products, the floor shift, the level sum and the registered
// read of the single-port 64K x 8 shade table in sequence, and no new pixel
// is accepted before the last one's result is loaded. A finished result
// waits in the output register while the next beat is accepted; a following
// result waits for it. Shade table entries hold no defined value until written.
module bilinear_fog_tile_shader (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata from bit 0: tile_x[12:0], tile_y[12:0], level_tl[7:0], level_tr[7:0],
  // level_bl[7:0], level_br[7:0], table_index[15:0], table_value[7:0],
  // old_pixel[7:0], zero fill
  input  logic [bfts_pkg::IN_DATA_BITS-1:0]   in_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]                          in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata from bit 0: visible_w[5:0], visible_h[5:0], screen_x[11:0],
  // screen_y[11:0], new_pixel[7:0], zero fill
  output logic [bfts_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  // tuser: kind
  output logic                                out_tuser,
  output logic                                out_tlast,
  // Configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [bfts_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [bfts_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic [bfts_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                                cfg_pready
);

  localparam int CB = bfts_pkg::COORD_BITS;
  localparam int SB = bfts_pkg::SIZE_BITS;

  // Clip window registers.
  logic [CB-1:0] win_min_x_r, win_min_y_r, win_max_x_r, win_max_y_r;
  logic          cfg_wr;
  bfts_pkg::reg_idx_t cfg_idx;

  bfts_pkg::cmd_t    cmd;
  bfts_pkg::status_t status;

  logic [SB-1:0] visible_w, visible_h;
  logic [CB-1:0] screen_x, screen_y;
  logic [bfts_pkg::COLOR_BITS-1:0] new_pixel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_min_x_r <= '0;
      win_min_y_r <= '0;
      win_max_x_r <= '1;
      win_max_y_r <= '1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bfts_pkg::REG_WIN_MIN_X: win_min_x_r <= cfg_pwdata[CB-1:0];
        bfts_pkg::REG_WIN_MIN_Y: win_min_y_r <= cfg_pwdata[CB-1:0];
        bfts_pkg::REG_WIN_MAX_X: win_max_x_r <= cfg_pwdata[CB-1:0];
        bfts_pkg::REG_WIN_MAX_Y: win_max_y_r <= cfg_pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (cfg_idx)
      bfts_pkg::REG_WIN_MIN_X: cfg_prdata = bfts_pkg::CFG_DATA_BITS'(win_min_x_r);
      bfts_pkg::REG_WIN_MIN_Y: cfg_prdata = bfts_pkg::CFG_DATA_BITS'(win_min_y_r);
      bfts_pkg::REG_WIN_MAX_X: cfg_prdata = bfts_pkg::CFG_DATA_BITS'(win_max_x_r);
      bfts_pkg::REG_WIN_MAX_Y: cfg_prdata = bfts_pkg::CFG_DATA_BITS'(win_max_y_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  bfts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bfts_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .win_min_x     (win_min_x_r),
    .win_min_y     (win_min_y_r),
    .win_max_x     (win_max_x_r),
    .win_max_y     (win_max_y_r),
    .tile_x        (in_tdata[12:0]),
    .tile_y        (in_tdata[25:13]),
    .level_tl      (in_tdata[33:26]),
    .level_tr      (in_tdata[41:34]),
    .level_bl      (in_tdata[49:42]),
    .level_br      (in_tdata[57:50]),
    .table_index   (in_tdata[73:58]),
    .table_value   (in_tdata[81:74]),
    .old_pixel     (in_tdata[89:82]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_kind      (out_tuser),
    .out_visible_w (visible_w),
    .out_visible_h (visible_h),
    .out_screen_x  (screen_x),
    .out_screen_y  (screen_y),
    .out_new_pixel (new_pixel),
    .out_last      (out_tlast)
  );

  // Pack the result beat.
  assign out_tdata = {4'b0000, new_pixel, screen_y, screen_x, visible_h, visible_w};

  // A tile answer is either fully clipped in both axes or visible in both.
  a_tile_size_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bfts_pkg::KIND_TILE) |->
      ((visible_w == '0) == (visible_h == '0)))
    else $error("tile answer clipped in one axis only");

  // A visible size never exceeds the tile.
  a_tile_size_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == bfts_pkg::KIND_TILE) |->
      (visible_w <= SB'(bfts_pkg::TILE_SIZE)) && (visible_h <= SB'(bfts_pkg::TILE_SIZE)))
    else $error("tile answer larger than the tile");

  // Only pixel results mark the end of a tile.
  a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_tuser == bfts_pkg::KIND_PIXEL))
    else $error("last marked on a tile answer");

  // A new result is loaded only when the output beat is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tile_load || cmd.px_load) |-> (!out_tvalid || out_tready))
    else $error("result loaded over a waiting beat");

endmodule

FILE: rtl/bfts_ram.sv
// Generic single-port RAM with a registered read port.
// Stand-alone; holds the shade table of the fog tile shader.
module bfts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read first port; the read data lands in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bfts_ctrl.sv
// Controller state machine of the fog tile shader.
// Depends on bfts_pkg; drives the datapath through cmd_t and reads status_t.
module bfts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  bfts_pkg::op_t      in_op,
  output logic               in_tready,
  input  bfts_pkg::status_t  status,
  output bfts_pkg::cmd_t     cmd
);

  bfts_pkg::state_t state_r;
  bfts_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      bfts_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_op)
            bfts_pkg::OP_TBL_WR: begin
              cmd.tbl_wr = 1'b1;
            end
            bfts_pkg::OP_TILE_START: begin
              cmd.tile_start = 1'b1;
              state_nxt      = bfts_pkg::ST_TILE_CLIP;
            end
            bfts_pkg::OP_PIXEL: begin
              // A pixel beat with no open tile is dropped.
              if (status.tile_active) begin
                cmd.px_start = 1'b1;
                state_nxt    = bfts_pkg::ST_PIX_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      bfts_pkg::ST_TILE_CLIP: begin
        cmd.tile_commit = 1'b1;
        state_nxt       = bfts_pkg::ST_TILE_RESP;
      end
      bfts_pkg::ST_TILE_RESP: begin
        if (status.out_free) begin
          cmd.tile_load = 1'b1;
          state_nxt     = bfts_pkg::ST_IDLE;
        end
      end
      bfts_pkg::ST_PIX_MUL: begin
        cmd.px_mul = 1'b1;
        state_nxt  = bfts_pkg::ST_PIX_DIV;
      end
      bfts_pkg::ST_PIX_DIV: begin
        cmd.px_div = 1'b1;
        state_nxt  = bfts_pkg::ST_PIX_ADDR;
      end
      bfts_pkg::ST_PIX_ADDR: begin
        cmd.px_addr = 1'b1;
        state_nxt   = bfts_pkg::ST_PIX_LOOK;
      end
      bfts_pkg::ST_PIX_LOOK: begin
        // The table read is in flight.
        state_nxt = bfts_pkg::ST_PIX_RESP;
      end
      bfts_pkg::ST_PIX_RESP: begin
        if (status.out_free) begin
          cmd.px_load = 1'b1;
          state_nxt   = bfts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/bfts_dp.sv
// Datapath of the fog tile shader: tile clipping, raster counters, level
// interpolation, shade table and output register. Depends on bfts_pkg, bfts_ram.
module bfts_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bfts_pkg::cmd_t                        cmd,
  output bfts_pkg::status_t                     status,
  input  logic [bfts_pkg::COORD_BITS-1:0]       win_min_x,
  input  logic [bfts_pkg::COORD_BITS-1:0]       win_min_y,
  input  logic [bfts_pkg::COORD_BITS-1:0]       win_max_x,
  input  logic [bfts_pkg::COORD_BITS-1:0]       win_max_y,
  input  logic [bfts_pkg::POS_BITS-1:0]         tile_x,
  input  logic [bfts_pkg::POS_BITS-1:0]         tile_y,
  input  logic [bfts_pkg::LEVEL_BITS-1:0]       level_tl,
  input  logic [bfts_pkg::LEVEL_BITS-1:0]       level_tr,
  input  logic [bfts_pkg::LEVEL_BITS-1:0]       level_bl,
  input  logic [bfts_pkg::LEVEL_BITS-1:0]       level_br,
  input  logic [bfts_pkg::TBL_ADDR_BITS-1:0]    table_index,
  input  logic [bfts_pkg::COLOR_BITS-1:0]       table_value,
  input  logic [bfts_pkg::COLOR_BITS-1:0]       old_pixel,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic                                  out_kind,
  output logic [bfts_pkg::SIZE_BITS-1:0]        out_visible_w,
  output logic [bfts_pkg::SIZE_BITS-1:0]        out_visible_h,
  output logic [bfts_pkg::COORD_BITS-1:0]       out_screen_x,
  output logic [bfts_pkg::COORD_BITS-1:0]       out_screen_y,
  output logic [bfts_pkg::COLOR_BITS-1:0]       out_new_pixel,
  output logic                                  out_last
);

  localparam int CB = bfts_pkg::COORD_BITS;
  localparam int SB = bfts_pkg::SIZE_BITS;
  localparam int TB = bfts_pkg::TILE_BITS;
  localparam int LB = bfts_pkg::LEVEL_BITS;
  localparam int FB = bfts_pkg::FRAC_BITS;
  localparam int QB = bfts_pkg::QUOT_BITS;
  localparam int DB = bfts_pkg::STEP_BITS;
  localparam int WB = CB + 2;

  // One axis of the clip result.
  typedef struct packed {
    logic          lo;
    logic          ok;
    logic [CB-1:0] pos;
    logic [SB-1:0] size;
  } axis_t;

  // Clip against the low window edge.
  function automatic axis_t clip_lo(input logic [CB:0] pos, input logic [CB-1:0] mn);
    axis_t         res;
    logic [WB-1:0] pos_w;
    logic [WB-1:0] mn_w;
    logic [WB-1:0] gap;
    logic [WB-1:0] left;
    pos_w    = {pos[CB], pos};
    mn_w     = {2'b00, mn};
    gap      = mn_w - pos_w;
    left     = WB'(bfts_pkg::TILE_SIZE) - gap;
    res.lo   = $signed(pos_w) < $signed(mn_w);
    if (res.lo) begin
      res.ok   = $signed(left) > 0;
      res.pos  = mn;
      res.size = left[SB-1:0];
    end else begin
      res.ok   = 1'b1;
      res.pos  = pos[CB-1:0];
      res.size = SB'(bfts_pkg::TILE_SIZE);
    end
    return res;
  endfunction

  // Clip against the high window edge.
  function automatic axis_t clip_hi(input axis_t a, input logic [CB-1:0] mx);
    axis_t         res;
    logic [WB-1:0] tail;
    logic [WB-1:0] lim;
    logic [WB-1:0] room;
    res  = a;
    tail = {2'b00, a.pos} + {{(WB-SB){1'b0}}, a.size};
    lim  = {2'b00, mx} + WB'(1);
    room = lim - {2'b00, a.pos};
    if (tail > lim) begin
      res.ok   = a.ok && ($signed(room) > 0);
      res.size = room[SB-1:0];
    end
    return res;
  endfunction

  // Tile clip stage registers.
  axis_t         ax_r, ay_r;
  logic [LB-1:0] lvl_r [4];

  // Open tile state.
  logic          tile_active_r;
  logic [CB-1:0] org_x_r, org_y_r;
  logic [SB-1:0] vis_w_r, vis_h_r;
  logic [1:0]    anchor_r;
  logic [TB-1:0] row_r, col_r;
  logic [LB-1:0] lvl_a_r, lvl_c_r;
  logic signed [DB-1:0] step_ab_r, step_cd_r;

  // Pixel pipeline registers.
  logic [TB-1:0] i_r, j_r;
  logic [bfts_pkg::COLOR_BITS-1:0] old_r;
  logic [CB-1:0] px_x_r, px_y_r;
  logic          px_last_r;
  logic [FB-1:0] from_r, to_r;
  logic signed [QB-1:0] quot_r;
  logic [bfts_pkg::TBL_ADDR_BITS-1:0] addr_r;

  // Output register.
  logic          out_valid_r;
  logic          out_kind_r;
  logic [SB-1:0] out_w_r, out_h_r;
  logic [CB-1:0] out_x_r, out_y_r;
  logic [bfts_pkg::COLOR_BITS-1:0] out_pix_r;
  logic          out_last_r;

  // Combinational helpers.
  axis_t         cx, cy;
  logic          tile_ok;
  logic [1:0]    anchor;
  logic [LB-1:0] pa, pb, pc, pd;
  logic [TB-1:0] i_nxt, j_nxt;
  logic          last_nxt;
  logic signed [DB+TB:0] mul_from, mul_to;
  logic [FB-1:0] diff;
  logic signed [QB+TB:0] mul_v;
  logic [FB-1:0] v_sum, v_rnd;
  logic [bfts_pkg::COLOR_BITS-1:0] ram_rdata;
  logic [bfts_pkg::TBL_ADDR_BITS-1:0] ram_addr;

  // Right and bottom clip on the registered left and top results.
  assign cx      = clip_hi(ax_r, win_max_x);
  assign cy      = clip_hi(ay_r, win_max_y);
  assign tile_ok = cx.ok && cy.ok;
  assign anchor  = {ay_r.lo, ax_r.lo};

  // Corner order as seen from the anchor corner.
  always_comb begin
    case (anchor)
      2'd0: begin
        pa = lvl_r[0]; pc = lvl_r[1]; pb = lvl_r[2]; pd = lvl_r[3];
      end
      2'd1: begin
        pa = lvl_r[1]; pc = lvl_r[0]; pb = lvl_r[3]; pd = lvl_r[2];
      end
      2'd2: begin
        pa = lvl_r[2]; pc = lvl_r[3]; pb = lvl_r[0]; pd = lvl_r[1];
      end
      default: begin
        pa = lvl_r[3]; pc = lvl_r[2]; pb = lvl_r[1]; pd = lvl_r[0];
      end
    endcase
  end

  // Distances from the anchor for the pixel at the current raster position.
  assign i_nxt    = anchor_r[1] ? TB'(vis_h_r - SB'(1) - {1'b0, row_r}) : row_r;
  assign j_nxt    = anchor_r[0] ? TB'(vis_w_r - SB'(1) - {1'b0, col_r}) : col_r;
  assign last_nxt = ({1'b0, row_r} == vis_h_r - SB'(1)) &&
                    ({1'b0, col_r} == vis_w_r - SB'(1));

  // Interpolation arithmetic: edge products, edge difference, row product and rounded sum.
  assign mul_from = $signed({1'b0, i_r}) * step_ab_r;
  assign mul_to   = $signed({1'b0, i_r}) * step_cd_r;
  assign diff     = to_r - from_r;
  assign mul_v    = $signed({1'b0, j_r}) * quot_r;
  assign v_sum    = from_r + mul_v[FB-1:0];
  assign v_rnd    = v_sum + bfts_pkg::LEVEL_ROUND;

  // Tile clip stage and corner levels.
  always_ff @(posedge clk) begin
    if (cmd.tile_start) begin
      ax_r     <= clip_lo(tile_x, win_min_x);
      ay_r     <= clip_lo(tile_y, win_min_y);
      lvl_r[0] <= level_tl;
      lvl_r[1] <= level_tr;
      lvl_r[2] <= level_bl;
      lvl_r[3] <= level_br;
    end
  end

  // Open tile state and raster counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_active_r <= 1'b0;
      row_r         <= '0;
      col_r         <= '0;
      vis_w_r       <= '0;
      vis_h_r       <= '0;
      anchor_r      <= '0;
    end else if (cmd.tile_start) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.tile_commit) begin
      tile_active_r <= tile_ok;
      if (tile_ok) begin
        vis_w_r  <= cx.size;
        vis_h_r  <= cy.size;
        anchor_r <= anchor;
      end else begin
        vis_w_r <= '0;
        vis_h_r <= '0;
      end
    end else if (cmd.px_start) begin
      if (last_nxt) begin
        tile_active_r <= 1'b0;
        row_r         <= '0;
        col_r         <= '0;
      end else if ({1'b0, col_r} + SB'(1) >= vis_w_r) begin
        col_r <= '0;
        row_r <= row_r + TB'(1);
      end else begin
        col_r <= col_r + TB'(1);
      end
    end
  end

  // Origin of a visible tile and anchor-ordered corner terms.
  always_ff @(posedge clk) begin
    if (cmd.tile_commit) begin
      if (tile_ok) begin
        org_x_r <= cx.pos;
        org_y_r <= cy.pos;
      end
      lvl_a_r   <= pa;
      lvl_c_r   <= pc;
      step_ab_r <= $signed({1'b0, pb, 3'b000}) - $signed({1'b0, pa, 3'b000});
      step_cd_r <= $signed({1'b0, pd, 3'b000}) - $signed({1'b0, pc, 3'b000});
    end
  end

  // Pixel pipeline.
  always_ff @(posedge clk) begin
    if (cmd.px_start) begin
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      old_r     <= old_pixel;
      px_x_r    <= org_x_r + CB'(col_r);
      px_y_r    <= org_y_r + CB'(row_r);
      px_last_r <= last_nxt;
    end
    if (cmd.px_mul) begin
      from_r <= {{(FB-2*LB){1'b0}}, lvl_a_r, {LB{1'b0}}} +
                {{(FB-DB-TB-1){mul_from[DB+TB]}}, mul_from};
      to_r   <= {{(FB-2*LB){1'b0}}, lvl_c_r, {LB{1'b0}}} +
                {{(FB-DB-TB-1){mul_to[DB+TB]}}, mul_to};
    end
    // Floor division by the tile size is an arithmetic shift.
    if (cmd.px_div) begin
      quot_r <= $signed(diff[FB-1:TB]);
    end
    if (cmd.px_addr) begin
      addr_r <= {v_rnd[2*LB-1:LB], old_r};
    end
  end

  // Shade table: written by table beats, otherwise read at the lookup address.
  assign ram_addr = cmd.tbl_wr ? table_index : addr_r;

  bfts_ram #(
    .WIDTH (bfts_pkg::COLOR_BITS),
    .DEPTH (bfts_pkg::TBL_DEPTH)
  ) u_shade_ram (
    .clk   (clk),
    .we    (cmd.tbl_wr),
    .addr  (ram_addr),
    .wdata (table_value),
    .rdata (ram_rdata)
  );

  // Output register; a new result loads only once the previous beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.tile_load || cmd.px_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tile_load) begin
      out_kind_r <= bfts_pkg::KIND_TILE;
      out_w_r    <= vis_w_r;
      out_h_r    <= vis_h_r;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_pix_r  <= '0;
      out_last_r <= 1'b0;
    end else if (cmd.px_load) begin
      out_kind_r <= bfts_pkg::KIND_PIXEL;
      out_w_r    <= '0;
      out_h_r    <= '0;
      out_x_r    <= px_x_r;
      out_y_r    <= px_y_r;
      out_pix_r  <= ram_rdata;
      out_last_r <= px_last_r;
    end
  end

  assign status.tile_active = tile_active_r;
  assign status.out_free    = !out_valid_r || out_tready;

  assign out_tvalid    = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_visible_w = out_w_r;
  assign out_visible_h = out_h_r;
  assign out_screen_x  = out_x_r;
  assign out_screen_y  = out_y_r;
  assign out_new_pixel = out_pix_r;
  assign out_last      = out_last_r;

endmodule
